@@ hw/rtl/mpcit_pkg.sv @@
package mpcit_pkg;

  localparam int COORD_BITS   = 24;
  localparam int RADIUS_BITS  = 23;
  localparam int TIME_BITS    = 32;
  localparam int TIME_FRAC    = 16;

  // derived widths
  localparam int DX_BITS      = COORD_BITS + 1;
  localparam int DSQ_BITS     = 2 * DX_BITS;
  localparam int A_BITS       = 2 * COORD_BITS;
  localparam int B_BITS       = 2 * DX_BITS;
  localparam int BM_BITS      = 2 * COORD_BITS + 1;
  localparam int RSQ_BITS     = 2 * RADIUS_BITS;
  localparam int CMP_BITS     = (DSQ_BITS > RSQ_BITS) ? DSQ_BITS : RSQ_BITS;
  localparam int C_BITS       = DSQ_BITS;
  localparam int DISC_BITS    = 2 * BM_BITS;
  localparam int ROOT_BITS    = BM_BITS;
  localparam int REM_BITS     = ROOT_BITS + 2;
  localparam int FRONT_STAGES = 6;

  typedef enum logic [2:0] {
    OC_OVERLAP    = 3'd0,
    OC_HIT        = 3'd1,
    OC_STATIONARY = 3'd2,
    OC_MISS       = 3'd3,
    OC_PASSED     = 3'd4
  } outcome_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] bullet_x;
    logic signed [COORD_BITS-1:0] bullet_y;
    logic signed [COORD_BITS-1:0] vel_x;
    logic signed [COORD_BITS-1:0] vel_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
  } in_word_t;

  typedef struct packed {
    outcome_t               outcome;
    logic [TIME_BITS-1:0]   impact_time;
  } out_word_t;

  typedef struct packed {
    outcome_t               outcome;
    logic [BM_BITS-1:0]     bm;
    logic [A_BITS-1:0]      a;
    logic [DISC_BITS-1:0]   rad;
    logic [REM_BITS-1:0]    rem;
    logic [ROOT_BITS-1:0]   root;
  } sq_word_t;

  typedef struct packed {
    outcome_t               outcome;
    logic                   sat;
    logic [A_BITS-1:0]      a;
    logic [A_BITS-1:0]      prem;
    logic [TIME_BITS-1:0]   low;
    logic [TIME_BITS-1:0]   quo;
  } dv_word_t;

endpackage

@@ hw/rtl/mpcit_front.sv @@
module mpcit_front import mpcit_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  in_word_t               in_data,
  input  logic [RADIUS_BITS-1:0] radius,
  output sq_word_t               sq_out
);

  localparam int BML = (BM_BITS + 1) / 2;
  localparam int BMH = BM_BITS - BML;
  localparam int AL  = (A_BITS + 1) / 2;
  localparam int AH  = A_BITS - AL;
  localparam int CL  = (C_BITS + 1) / 2;
  localparam int CH  = C_BITS - CL;

  // stage 1: offsets
  logic signed [DX_BITS-1:0]    dx_r, dy_r;
  logic signed [COORD_BITS-1:0] vx_r, vy_r;
  logic [RADIUS_BITS-1:0]       rad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DX_BITS'(in_data.bullet_x) - DX_BITS'(in_data.target_x);
      dy_r  <= DX_BITS'(in_data.bullet_y) - DX_BITS'(in_data.target_y);
      vx_r  <= in_data.vel_x;
      vy_r  <= in_data.vel_y;
      rad_r <= radius;
    end
  end

  // stage 2: products
  logic signed [DSQ_BITS-1:0] dxx_r, dyy_r, dxv_r, dyv_r;
  logic signed [A_BITS-1:0]   vxx_r, vyy_r;
  logic [RSQ_BITS-1:0]        rsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      dxv_r <= dx_r * vx_r;
      dyv_r <= dy_r * vy_r;
      vxx_r <= vx_r * vx_r;
      vyy_r <= vy_r * vy_r;
      rsq_r <= rad_r * rad_r;
    end
  end

  // stage 3: dot products and early outcomes
  logic [DSQ_BITS-1:0]      dsq;
  logic [A_BITS-1:0]        asum;
  logic [C_BITS-1:0]        c3_r;
  logic [A_BITS-1:0]        a3_r;
  logic signed [B_BITS-1:0] b3_r;
  outcome_t                 oc3_r, oc3_nxt;

  always_comb begin
    dsq  = $unsigned(dxx_r) + $unsigned(dyy_r);
    asum = $unsigned(vxx_r) + $unsigned(vyy_r);
    if (CMP_BITS'(dsq) <= CMP_BITS'(rsq_r)) begin
      oc3_nxt = OC_OVERLAP;
    end else if (asum == '0) begin
      oc3_nxt = OC_STATIONARY;
    end else begin
      oc3_nxt = OC_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r  <= C_BITS'(CMP_BITS'(dsq) - CMP_BITS'(rsq_r));
      a3_r  <= asum;
      b3_r  <= dxv_r + dyv_r;
      oc3_r <= oc3_nxt;
    end
  end

  // stage 4: partial products of b*b and a*c
  logic [BM_BITS-1:0]     bm;
  logic [BM_BITS-1:0]     bm4_r;
  logic [A_BITS-1:0]      a4_r;
  logic                   bpos4_r;
  outcome_t               oc4_r;
  logic [2*BML-1:0]       bll_r;
  logic [BML+BMH-1:0]     blh_r;
  logic [2*BMH-1:0]       bhh_r;
  logic [AL+CL-1:0]       alcl_r;
  logic [AL+CH-1:0]       alch_r;
  logic [AH+CL-1:0]       ahcl_r;
  logic [AH+CH-1:0]       ahch_r;

  always_comb begin
    bm = b3_r[B_BITS-1] ? BM_BITS'(-b3_r) : BM_BITS'(b3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bm4_r   <= bm;
      a4_r    <= a3_r;
      bpos4_r <= !b3_r[B_BITS-1] && (b3_r != '0);
      oc4_r   <= oc3_r;
      bll_r   <= bm[BML-1:0] * bm[BML-1:0];
      blh_r   <= bm[BML-1:0] * bm[BM_BITS-1:BML];
      bhh_r   <= bm[BM_BITS-1:BML] * bm[BM_BITS-1:BML];
      alcl_r  <= a3_r[AL-1:0] * c3_r[CL-1:0];
      alch_r  <= a3_r[AL-1:0] * c3_r[C_BITS-1:CL];
      ahcl_r  <= a3_r[A_BITS-1:AL] * c3_r[CL-1:0];
      ahch_r  <= a3_r[A_BITS-1:AL] * c3_r[C_BITS-1:CL];
    end
  end

  // stage 5: sum partial products
  logic [DISC_BITS-1:0] bsq5_r, ac5_r;
  logic [BM_BITS-1:0]   bm5_r;
  logic [A_BITS-1:0]    a5_r;
  logic                 bpos5_r;
  outcome_t             oc5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bsq5_r  <= (DISC_BITS'(bhh_r) << (2 * BML)) + (DISC_BITS'(blh_r) << (BML + 1))
                 + DISC_BITS'(bll_r);
      ac5_r   <= (DISC_BITS'(ahch_r) << (AL + CL)) + (DISC_BITS'(alch_r) << CL)
                 + (DISC_BITS'(ahcl_r) << AL) + DISC_BITS'(alcl_r);
      bm5_r   <= bm4_r;
      a5_r    <= a4_r;
      bpos5_r <= bpos4_r;
      oc5_r   <= oc4_r;
    end
  end

  // stage 6: discriminant, miss and past tests
  logic [DISC_BITS:0] diff;
  outcome_t           oc6;
  sq_word_t           sq_r;

  always_comb begin
    diff = {1'b0, bsq5_r} - {1'b0, ac5_r};
    oc6  = oc5_r;
    if (oc5_r == OC_HIT) begin
      if (diff[DISC_BITS]) begin
        oc6 = OC_MISS;
      end else if (bpos5_r) begin
        oc6 = OC_PASSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r.outcome <= oc6;
      sq_r.bm      <= bm5_r;
      sq_r.a       <= a5_r;
      sq_r.rad     <= diff[DISC_BITS-1:0];
      sq_r.rem     <= '0;
      sq_r.root    <= '0;
    end
  end

  assign sq_out = sq_r;

endmodule

@@ hw/rtl/mpcit_sqrt_cell.sv @@
module mpcit_sqrt_cell import mpcit_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  sq_word_t d_in,
  output sq_word_t d_out
);

  // one root bit per cell, restoring
  logic [REM_BITS+1:0] rem2, trial;
  logic                ge;
  sq_word_t            cell_nxt, cell_r;

  always_comb begin
    rem2  = {d_in.rem, d_in.rad[DISC_BITS-1 -: 2]};
    trial = (REM_BITS+2)'({d_in.root, 2'b01});
    ge    = rem2 >= trial;
    cell_nxt      = d_in;
    cell_nxt.rem  = ge ? REM_BITS'(rem2 - trial) : REM_BITS'(rem2);
    cell_nxt.root = {d_in.root[ROOT_BITS-2:0], ge};
    cell_nxt.rad  = d_in.rad << 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

@@ hw/rtl/mpcit_div_cell.sv @@
module mpcit_div_cell import mpcit_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  dv_word_t d_in,
  output dv_word_t d_out
);

  // one quotient bit per cell, restoring
  logic [A_BITS:0] r2, dvs;
  logic            ge;
  dv_word_t        cell_nxt, cell_r;

  always_comb begin
    r2  = {d_in.prem, d_in.low[TIME_BITS-1]};
    dvs = {1'b0, d_in.a};
    ge  = r2 >= dvs;
    cell_nxt      = d_in;
    cell_nxt.prem = ge ? A_BITS'(r2 - dvs) : A_BITS'(r2);
    cell_nxt.low  = d_in.low << 1;
    cell_nxt.quo  = {d_in.quo[TIME_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

@@ hw/rtl/moving_point_circle_impact_time.sv @@
// each word goes via front end, root cells, numerator, divider cells, output queue
// throughput: one word per cycle unless the queue is full and stalled, set by the
//   fully pipelined front end, 49-cell square root chain and 32-cell divider chain
// a two-word output queue lets the pipe keep accepting while one result waits
// reset: synchronous, active low; clears pipe valid bits, queue and radius
module moving_point_circle_impact_time import mpcit_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_we,
  input  logic [RADIUS_BITS-1:0] cfg_wdata
);

  // stage map: front end, root cells, numerator stage, divider cells
  localparam int NST  = FRONT_STAGES + ROOT_BITS + 1 + TIME_BITS;
  localparam int LAST = NST - 1;

  // combined radius register
  logic [RADIUS_BITS-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // whole pipe moves together; it only halts when the queue is full and not draining
  logic [1:0]     cnt_r, cnt_nxt;
  logic           adv;
  logic [NST-1:0] v_r;

  assign adv      = (cnt_r != 2'd2) || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // front end: offsets, products, dot products, discriminant
  sq_word_t sq_w [ROOT_BITS+1];

  mpcit_front u_front (
    .clk     (clk),
    .en      (adv),
    .in_data (in_data),
    .radius  (radius_r),
    .sq_out  (sq_w[0])
  );

  // square root chain, one root bit per cell
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    mpcit_sqrt_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq_w[k]),
      .d_out (sq_w[k+1])
    );
  end

  // numerator -b - s, and saturation when the quotient reaches 2^32
  logic [BM_BITS-1:0] num;
  dv_word_t           dv_w [TIME_BITS+1];
  dv_word_t           nm_r;

  assign num = sq_w[ROOT_BITS].bm - sq_w[ROOT_BITS].root;

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_r.outcome <= sq_w[ROOT_BITS].outcome;
      nm_r.sat     <= num[BM_BITS-1:TIME_FRAC] >= sq_w[ROOT_BITS].a;
      nm_r.a       <= sq_w[ROOT_BITS].a;
      nm_r.prem    <= A_BITS'(num[BM_BITS-1:TIME_FRAC]);
      nm_r.low     <= {num[TIME_FRAC-1:0], {(TIME_BITS-TIME_FRAC){1'b0}}};
      nm_r.quo     <= '0;
    end
  end

  assign dv_w[0] = nm_r;

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < TIME_BITS; k++) begin : g_div
    mpcit_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (dv_w[k]),
      .d_out (dv_w[k+1])
    );
  end

  // result word
  out_word_t res;

  always_comb begin
    res.outcome     = dv_w[TIME_BITS].outcome;
    res.impact_time = '0;
    if (dv_w[TIME_BITS].outcome == OC_HIT) begin
      res.impact_time = dv_w[TIME_BITS].sat ? '1 : dv_w[TIME_BITS].quo;
    end
  end

  // two-word output queue, head at slot 0
  out_word_t q_r [2];
  out_word_t q_nxt [2];
  logic      push, pop;
  logic [1:0] widx;

  assign push = adv && v_r[LAST];
  assign pop  = out_valid && out_ready;

  always_comb begin
    q_nxt   = q_r;
    widx    = cnt_r - {1'b0, pop};
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push) begin
      q_nxt[widx[0]] = res;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];

  // only a hit carries a time
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome != OC_HIT) |-> out_data.impact_time == '0)
    else $error("nonzero time on a non-hit result");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !out_ready |-> !in_ready)
    else $error("input taken while queue full and stalled");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted word lost at pipe entry");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count overflow");

endmodule
